// File: rtl/hacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacl_pkg - shared types and constants for the hi-res artifact colour line
// Palette tables, screen limits, the decoded-byte record and the colour to
// ARGB lookup.
// ----------------------------------------------------------------------------
package hacl_pkg;

  // Pixels produced for one video byte; the last one repeats bit 6
  localparam int unsigned PixPerByte = 8;
  localparam int unsigned BitsPerByte = 7;

  // Screen limits in source terms (line and byte column)
  localparam logic [7:0] LineLimit      = 8'd192;
  localparam logic [7:0] MixedLineLimit = 8'd168;
  localparam logic [5:0] ColLimit       = 6'd40;

  // Two-bit artifact index to 4-bit colour, entry 0 in the low nibble
  localparam logic [3:0][3:0] Pal0Map = {4'hF, 4'h2, 4'h5, 4'h0};
  localparam logic [3:0][3:0] Pal1Map = {4'hF, 4'h1, 4'h6, 4'h0};

  // Intensity byte ORed in per colour bit
  localparam logic [7:0] FullIntensity = 8'hFF;

  // One decoded video byte, handed from the decoder to the serialiser
  typedef struct packed {
    logic [7:0]      line;
    logic [5:0]      col;
    logic            row_ok;
    logic            col_ok;
    logic [7:0][3:0] colour;
  } hacl_byte_t;

  // Base palette entry ORed with the intensity bits of the colour
  function automatic logic [31:0] colour_to_argb(input logic [3:0] c);
    logic [31:0] v;
    case (c)
      4'h0:    v = 32'hFF000000;
      4'h1:    v = 32'hFFEA5D15;
      4'h2:    v = 32'hFF43C300;
      4'h5:    v = 32'hFFB63DFF;
      4'h6:    v = 32'hFF10A4E3;
      4'hF:    v = 32'hFFFFFFFF;
      default: v = 32'h00000000;
    endcase
    if (c[2]) v[7:0]   = v[7:0]   | FullIntensity;
    if (c[1]) v[15:8]  = v[15:8]  | FullIntensity;
    if (c[0]) v[23:16] = v[23:16] | FullIntensity;
    return v;
  endfunction

endpackage

// File: rtl/hacl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacl_cfg - configuration register file
// APB-style slave holding the mixed-mode bit; zero wait states.
// ----------------------------------------------------------------------------
module hacl_cfg
  import hacl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        mixed_mode_o
);

  logic mixed_mode_q, mixed_mode_d;
  logic wr_en;
  logic sel_mixed;

  // Register 0 sits at byte address 0; address bit 2 selects beyond the list
  assign sel_mixed = (paddr[2] == 1'b0);
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready & sel_mixed;

  always_comb begin
    mixed_mode_d = mixed_mode_q;
    if (wr_en) mixed_mode_d = pwdata[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mixed_mode_q <= 1'b0;
    end else begin
      mixed_mode_q <= mixed_mode_d;
    end
  end

  // Read back
  assign prdata       = sel_mixed ? {31'd0, mixed_mode_q} : 32'd0;
  assign mixed_mode_o = mixed_mode_q;

endmodule

// File: rtl/hacl_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacl_decode - artifact colour decoder
// Turns one video byte into eight 4-bit colours and keeps the carried bit
// between bytes of a line.
// ----------------------------------------------------------------------------
module hacl_decode
  import hacl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] video_byte_i,
  input  logic [5:0] byte_column_i,
  input  logic [7:0] scan_line_i,
  input  logic       mixed_mode_i,
  output hacl_byte_t dec_o
);

  logic       prev_bit_q, prev_bit_d;
  logic       prev_start;
  logic [6:0] prev_vec;
  logic [1:0] idx [BitsPerByte];

  // Carried bit restarts at column 0
  assign prev_start = (byte_column_i == 6'd0) ? 1'b0 : prev_bit_q;
  assign prev_vec   = {video_byte_i[5:0], prev_start};

  // Per-bit index and palette lookup; the bit pairs are independent
  always_comb begin
    dec_o.line   = scan_line_i;
    dec_o.col    = byte_column_i;
    dec_o.col_ok = (byte_column_i < ColLimit);
    dec_o.row_ok = (scan_line_i < LineLimit) &&
                   !(mixed_mode_i && (scan_line_i >= MixedLineLimit));
    for (int k = 0; k < BitsPerByte; k++) begin
      // odd column plus bit position: current bit is the high half
      if (byte_column_i[0] ^ k[0])
        idx[k] = {video_byte_i[k], prev_vec[k]};
      else
        idx[k] = {prev_vec[k], video_byte_i[k]};
      dec_o.colour[k] = video_byte_i[7] ? Pal1Map[idx[k]] : Pal0Map[idx[k]];
    end
    // eighth pixel stretches bit 6
    dec_o.colour[7] = dec_o.colour[6];
  end

  always_comb begin
    prev_bit_d = prev_bit_q;
    if (accept_i) prev_bit_d = video_byte_i[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bit_q <= 1'b0;
    end else begin
      prev_bit_q <= prev_bit_d;
    end
  end

endmodule

// File: rtl/hacl_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacl_serial - byte buffer and pixel serialiser
// Holds one decoded byte and issues its eight pixels, one per cycle while the
// output is not stalled, into the registered output stage.
// ----------------------------------------------------------------------------
module hacl_serial
  import hacl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hacl_byte_t  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_line_o,
  output logic [8:0]  out_pcol_o,
  output logic [3:0]  out_colour_o,
  output logic [31:0] out_argb_o,
  output logic        out_visible_o,
  output logic        out_last_o
);

  hacl_byte_t  buf_q, buf_d;
  logic        buf_valid_q, buf_valid_d;
  logic [2:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  line_q, line_d;
  logic [8:0]  pcol_q, pcol_d;
  logic [3:0]  colour_q, colour_d;
  logic [31:0] argb_q, argb_d;
  logic        visible_q, visible_d;
  logic        last_q, last_d;
  logic        issue;
  logic        issue_last;
  logic        accept;

  // A pixel moves on whenever the output stage is free or being drained
  assign issue      = buf_valid_q & (~out_valid_q | out_ready_i);
  assign issue_last = issue & (k_q == 3'(PixPerByte - 1));
  assign in_ready_o = ~buf_valid_q | issue_last;
  assign accept     = in_valid_i & in_ready_o;

  // Buffer and pixel counter
  always_comb begin
    buf_d       = buf_q;
    buf_valid_d = buf_valid_q;
    k_d         = k_q;
    if (issue) k_d = k_q + 3'd1;
    if (issue_last) buf_valid_d = 1'b0;
    if (accept) begin
      buf_d       = in_byte_i;
      buf_valid_d = 1'b1;
    end
  end

  // Output stage
  always_comb begin
    out_valid_d = out_valid_q;
    line_d      = line_q;
    pcol_d      = pcol_q;
    colour_d    = colour_q;
    argb_d      = argb_q;
    visible_d   = visible_q;
    last_d      = last_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (issue) begin
      out_valid_d = 1'b1;
      line_d      = buf_q.line;
      pcol_d      = {buf_q.col, k_q};
      colour_d    = buf_q.colour[k_q];
      argb_d      = colour_to_argb(buf_q.colour[k_q]);
      visible_d   = buf_q.row_ok & buf_q.col_ok;
      last_d      = (k_q == 3'(PixPerByte - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    buf_q    <= buf_d;
    line_q   <= line_d;
    pcol_q   <= pcol_d;
    colour_q <= colour_d;
    argb_q   <= argb_d;
    visible_q <= visible_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_line_o    = line_q;
  assign out_pcol_o    = pcol_q;
  assign out_colour_o  = colour_q;
  assign out_argb_o    = argb_q;
  assign out_visible_o = visible_q;
  assign out_last_o    = last_q;

  // Counter idles at zero with no byte held
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !buf_valid_q |-> k_q == 3'd0)
    else $error("pixel counter moved with no byte buffered");

  // Last pixel of a byte sits at the end of its eight-column group
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> pcol_q[2:0] == 3'd7)
    else $error("last pixel flag on wrong column");

  // Pixels of one byte follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !last_q |=> out_valid_q)
    else $error("gap inside a byte's pixel run");

endmodule

// File: rtl/hires_artifact_color_line_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hires_artifact_color_line_core - hi-res artifact colour line renderer
// Path: a taken byte is held in the byte buffer, then each pixel is registered
// in the output stage. One pixel per cycle while the output is not stalled;
// the serialiser sets the rate, and the next byte is taken with the last pixel.
// Reset: asynchronous, active low; clears the carried bit, mixed mode and
// all valid flags.
// ----------------------------------------------------------------------------
module hires_artifact_color_line_core
  import hacl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Video byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] video_byte, [13:8] byte_column, [21:14] scan_line, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  // Pixel stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] line_pair, [16:8] pixel_column, [20:17] color_index,
  // [52:21] argb, [55:53] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] visible
  output logic        m_axis_tuser,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        mixed_mode;
  logic        accept;
  hacl_byte_t  dec;
  logic [7:0]  line;
  logic [8:0]  pcol;
  logic [3:0]  colour;
  logic [31:0] argb;

  assign accept = s_axis_tvalid & s_axis_tready;

  hacl_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mixed_mode_o (mixed_mode)
  );

  hacl_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .video_byte_i  (s_axis_tdata[7:0]),
    .byte_column_i (s_axis_tdata[13:8]),
    .scan_line_i   (s_axis_tdata[21:14]),
    .mixed_mode_i  (mixed_mode),
    .dec_o         (dec)
  );

  hacl_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (dec),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_line_o    (line),
    .out_pcol_o    (pcol),
    .out_colour_o  (colour),
    .out_argb_o    (argb),
    .out_visible_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, argb, colour, pcol, line};

endmodule
